// File: hw/rtl/ahr_pkg.sv
// ----------------------------------------------------------------------------
// ahr_pkg
// Shared constants, codes and controller/datapath interface types for the
// audio history ring with replay.
// ----------------------------------------------------------------------------
package ahr_pkg;

  localparam int HISTORY_BYTES = 65536;
  localparam int HIST_AW       = $clog2(HISTORY_BYTES);
  localparam int FILL_W        = HIST_AW + 1;
  localparam int MAX_CLIENTS   = 4;
  localparam int CID_W         = (MAX_CLIENTS > 1) ? $clog2(MAX_CLIENTS) : 1;
  localparam int CCOUNT_W      = $clog2(MAX_CLIENTS + 1);

  // field widths
  localparam int OP_W     = 2;
  localparam int BYTE_W   = 8;
  localparam int ID_W     = 4;
  localparam int MS_W     = 12;
  localparam int CH_W     = 4;
  localparam int RATE_W   = 6;
  localparam int SB_W     = 3;
  localparam int KIND_W   = 2;
  localparam int STATUS_W = 3;
  localparam int P1_W     = MS_W + CH_W;
  localparam int P2_W     = P1_W + RATE_W;
  localparam int DEPTH_W  = P2_W + SB_W;

  localparam int S_TDATA_W = 32;
  localparam int M_TDATA_W = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 6;

  // operations
  localparam logic [OP_W-1:0] OP_STREAM   = 2'd0;
  localparam logic [OP_W-1:0] OP_REGISTER = 2'd1;
  localparam logic [OP_W-1:0] OP_DRAIN    = 2'd2;
  localparam logic [OP_W-1:0] OP_TICK     = 2'd3;

  // result kinds
  localparam logic [KIND_W-1:0] KIND_PASS   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_REPLAY = 2'd1;
  localparam logic [KIND_W-1:0] KIND_STATUS = 2'd2;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK           = 3'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_ID       = 3'd1;
  localparam logic [STATUS_W-1:0] ST_DUPLICATE    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_SINK_BUSY    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_SHORT        = 3'd4;
  localparam logic [STATUS_W-1:0] ST_NOT_DRAINING = 3'd5;

  // modes
  localparam logic [1:0] MODE_BUFFERING = 2'd0;
  localparam logic [1:0] MODE_DRAINING  = 2'd1;
  localparam logic [1:0] MODE_ON_DEMAND = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_CHANNELS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_RATE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_BYTES = 2'd2;

  typedef struct packed {
    logic load;    // capture the input transfer
    logic mul1;    // ms * channels
    logic mul2;    // * rate
    logic mul3;    // * sample bytes
    logic rd_en;   // read ring at replay position
    logic commit;  // update state and load the output register
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } status_t;

endpackage

// File: hw/rtl/ahr_ram.sv
// ----------------------------------------------------------------------------
// ahr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ahr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hw/rtl/ahr_ctrl.sv
// ----------------------------------------------------------------------------
// ahr_ctrl
// Sequencer: takes one item, steps the depth multiply or the ring read when
// the operation needs one, then commits once the output register is free.
// ----------------------------------------------------------------------------
module ahr_ctrl (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  input  logic [ahr_pkg::OP_W-1:0] in_op,
  output logic                     in_ready,
  input  ahr_pkg::status_t         status,
  output ahr_pkg::cmd_t            cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL1 = 3'd1;
  localparam logic [2:0] S_MUL2 = 3'd2;
  localparam logic [2:0] S_MUL3 = 3'd3;
  localparam logic [2:0] S_READ = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          case (in_op)
            ahr_pkg::OP_DRAIN: state_next = S_MUL1;
            ahr_pkg::OP_TICK:  state_next = S_READ;
            default:           state_next = S_FIN;
          endcase
        end
      end
      S_MUL1: begin
        cmd.mul1   = 1'b1;
        state_next = S_MUL2;
      end
      S_MUL2: begin
        cmd.mul2   = 1'b1;
        state_next = S_MUL3;
      end
      S_MUL3: begin
        cmd.mul3   = 1'b1;
        state_next = S_FIN;
      end
      S_READ: begin
        cmd.rd_en  = 1'b1;
        state_next = S_FIN;
      end
      S_FIN: begin
        if (status.out_free) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// File: hw/rtl/ahr_datapath.sv
// ----------------------------------------------------------------------------
// ahr_datapath
// History ring, fill/replay counters, client table, depth multiplier,
// configuration registers and the output register.
// ----------------------------------------------------------------------------
module ahr_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  ahr_pkg::cmd_t                       cmd,
  output ahr_pkg::status_t                    status,
  input  logic [ahr_pkg::OP_W-1:0]            in_op,
  input  logic [ahr_pkg::S_TDATA_W-1:0]       in_data,
  input  logic                                cfg_we,
  input  logic [ahr_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [ahr_pkg::CFG_W-1:0]           cfg_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [ahr_pkg::M_TDATA_W-1:0]       out_data,
  output logic [ahr_pkg::KIND_W-1:0]          out_kind,
  output logic                                out_last
);

  localparam int AW = ahr_pkg::HIST_AW;
  localparam int FW = ahr_pkg::FILL_W;
  localparam int NC = ahr_pkg::MAX_CLIENTS;

  // configuration
  logic [ahr_pkg::CH_W-1:0]   num_channels;
  logic [ahr_pkg::RATE_W-1:0] sample_rate_khz;
  logic [ahr_pkg::SB_W-1:0]   sample_bytes;

  // captured item
  logic [ahr_pkg::OP_W-1:0]   op;
  logic [ahr_pkg::BYTE_W-1:0] stream_byte;
  logic [ahr_pkg::ID_W-1:0]   client_id;
  logic [ahr_pkg::MS_W-1:0]   history_ms;
  logic                       sink_ready;

  logic [ahr_pkg::P1_W-1:0]    p1;
  logic [ahr_pkg::P2_W-1:0]    p2;
  logic [ahr_pkg::DEPTH_W-1:0] depth;

  // block state
  logic [AW-1:0]                    write_position;
  logic [FW-1:0]                    fill_count;
  logic                             store_full;
  logic [1:0]                       mode;
  logic [AW-1:0]                    replay_position;
  logic [FW-1:0]                    replay_remaining;
  logic [NC-1:0]                    client_registered;
  logic [ahr_pkg::MS_W-1:0]         client_depth_ms [NC];
  logic [ahr_pkg::CCOUNT_W-1:0]     client_count;

  logic [ahr_pkg::BYTE_W-1:0] ram_rdata;

  // commit results
  logic [ahr_pkg::KIND_W-1:0]   res_kind;
  logic                         res_dest;
  logic [ahr_pkg::BYTE_W-1:0]   res_byte;
  logic [ahr_pkg::STATUS_W-1:0] res_status;
  logic                         res_last;

  logic [ahr_pkg::CID_W-1:0] cidx;
  logic                      id_high;
  logic [FW-1:0]             avail;
  logic                      ram_we;

  assign cidx    = client_id[ahr_pkg::CID_W-1:0];
  assign id_high = ({1'b0, client_id} >= (ahr_pkg::ID_W+1)'(NC));
  assign avail   = store_full ? FW'(ahr_pkg::HISTORY_BYTES) : fill_count;
  assign ram_we  = cmd.commit && (op == ahr_pkg::OP_STREAM);

  assign status.out_free = !out_valid || out_ready;

  ahr_ram #(
    .WIDTH(ahr_pkg::BYTE_W),
    .DEPTH(ahr_pkg::HISTORY_BYTES)
  ) u_ring (
    .clk  (clk),
    .we   (ram_we),
    .waddr(write_position),
    .wdata(stream_byte),
    .re   (cmd.rd_en),
    .raddr(replay_position),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      num_channels    <= ahr_pkg::CH_W'(2);
      sample_rate_khz <= ahr_pkg::RATE_W'(16);
      sample_bytes    <= ahr_pkg::SB_W'(2);
    end else if (cfg_we) begin
      case (cfg_index)
        ahr_pkg::CFG_NUM_CHANNELS: num_channels    <= cfg_data[ahr_pkg::CH_W-1:0];
        ahr_pkg::CFG_SAMPLE_RATE:  sample_rate_khz <= cfg_data[ahr_pkg::RATE_W-1:0];
        ahr_pkg::CFG_SAMPLE_BYTES: sample_bytes    <= cfg_data[ahr_pkg::SB_W-1:0];
        default: ;
      endcase
    end
  end

  // input capture and depth multiply chain, one multiply per cycle
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op          <= in_op;
      stream_byte <= in_data[7:0];
      client_id   <= in_data[11:8];
      history_ms  <= in_data[23:12];
      sink_ready  <= in_data[24];
    end
    if (cmd.mul1) begin
      p1 <= history_ms * num_channels;
    end
    if (cmd.mul2) begin
      p2 <= p1 * sample_rate_khz;
    end
    if (cmd.mul3) begin
      depth <= p2 * sample_bytes;
    end
  end

  always_comb begin
    res_kind   = ahr_pkg::KIND_STATUS;
    res_dest   = 1'b0;
    res_byte   = '0;
    res_status = ahr_pkg::ST_OK;
    res_last   = 1'b0;
    case (op)
      ahr_pkg::OP_STREAM: begin
        res_kind = ahr_pkg::KIND_PASS;
        res_dest = (mode == ahr_pkg::MODE_ON_DEMAND);
        res_byte = stream_byte;
      end
      ahr_pkg::OP_REGISTER: begin
        if (id_high || client_count >= ahr_pkg::CCOUNT_W'(NC)) begin
          res_status = ahr_pkg::ST_BAD_ID;
        end else if (client_registered[cidx]) begin
          res_status = ahr_pkg::ST_DUPLICATE;
        end
      end
      ahr_pkg::OP_DRAIN: begin
        if (id_high || !client_registered[cidx]) begin
          res_status = ahr_pkg::ST_BAD_ID;
        end else if (!sink_ready) begin
          res_status = ahr_pkg::ST_SINK_BUSY;
        end else if (depth > ahr_pkg::DEPTH_W'(avail)) begin
          res_status = ahr_pkg::ST_SHORT;
        end
      end
      ahr_pkg::OP_TICK: begin
        if (mode != ahr_pkg::MODE_DRAINING || replay_remaining == '0) begin
          res_status = ahr_pkg::ST_NOT_DRAINING;
        end else begin
          res_kind = ahr_pkg::KIND_REPLAY;
          res_dest = 1'b1;
          res_byte = ram_rdata;
          res_last = (replay_remaining == FW'(1));
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_position    <= '0;
      fill_count        <= '0;
      store_full        <= 1'b0;
      mode              <= ahr_pkg::MODE_BUFFERING;
      replay_position   <= '0;
      replay_remaining  <= '0;
      client_registered <= '0;
      client_count      <= '0;
      for (int i = 0; i < NC; i++) begin
        client_depth_ms[i] <= '0;
      end
    end else if (cmd.commit) begin
      case (op)
        ahr_pkg::OP_STREAM: begin
          write_position <= write_position + AW'(1);
          if (fill_count < FW'(ahr_pkg::HISTORY_BYTES)) begin
            fill_count <= fill_count + FW'(1);
          end
          if (fill_count >= FW'(ahr_pkg::HISTORY_BYTES - 1)) begin
            store_full <= 1'b1;
          end
        end
        ahr_pkg::OP_REGISTER: begin
          if (res_status == ahr_pkg::ST_OK) begin
            client_registered[cidx] <= 1'b1;
            client_depth_ms[cidx]   <= history_ms;
            client_count            <= client_count + ahr_pkg::CCOUNT_W'(1);
          end
        end
        ahr_pkg::OP_DRAIN: begin
          if (res_status == ahr_pkg::ST_OK) begin
            // depth fits the ring here, so the low bits wrap correctly
            replay_position  <= write_position - depth[AW-1:0];
            replay_remaining <= depth[FW-1:0];
            mode <= (depth == '0) ? ahr_pkg::MODE_ON_DEMAND : ahr_pkg::MODE_DRAINING;
          end
        end
        ahr_pkg::OP_TICK: begin
          if (res_kind == ahr_pkg::KIND_REPLAY) begin
            replay_position  <= replay_position + AW'(1);
            replay_remaining <= replay_remaining - FW'(1);
            if (res_last) begin
              mode <= ahr_pkg::MODE_ON_DEMAND;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_data <= {4'b0, res_status, res_byte, res_dest};
      out_kind <= res_kind;
      out_last <= res_last;
    end
  end

endmodule

// File: hw/rtl/audio_history_ring_with_replay_core.sv
// ----------------------------------------------------------------------------
// audio_history_ring_with_replay_core
// Audio history ring with client registration and lookback replay.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one command per transfer: s_tuser is the operation (stream
//   byte, register client, begin drain, drain tick), s_tdata its fields.
//   m_* returns exactly one result per command: m_tuser is the result kind,
//   m_tdata destination/byte/status, m_tlast marks the final replayed byte.
//   cfg_we/cfg_index/cfg_data write channels, rate and sample size; write
//   only while no command is in flight.
// Steps: a command is captured when taken; stream and register commands
//   then go to the commit step, a drain tick first does a registered ring
//   read, and begin drain first runs three chained multiplies forming the
//   byte count. Each commit loads the output register. One command is in
//   flight at a time, so a new command is taken only once the last one
//   has committed.
// Reset: counters, mode and client table clear; the ring is not cleared,
//   only entries already written are ever replayed.
// Stall: a result waits in the output register; the next command is still
//   taken and held at its final step until the register frees up.
// ----------------------------------------------------------------------------
module audio_history_ring_with_replay_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // [7:0] stream_byte, [11:8] client_id, [23:12] history_ms, [24] sink_ready
  input  logic [ahr_pkg::S_TDATA_W-1:0]     s_tdata,
  // [1:0] operation
  input  logic [ahr_pkg::OP_W-1:0]          s_tuser,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // [0] destination, [8:1] data_byte, [11:9] status_code
  output logic [ahr_pkg::M_TDATA_W-1:0]     m_tdata,
  // [1:0] result_kind
  output logic [ahr_pkg::KIND_W-1:0]        m_tuser,
  output logic                              m_tlast,
  input  logic                              cfg_we,
  input  logic [ahr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ahr_pkg::CFG_W-1:0]         cfg_data
);

  ahr_pkg::cmd_t    cmd;
  ahr_pkg::status_t status;

  ahr_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(s_tvalid),
    .in_op   (s_tuser),
    .in_ready(s_tready),
    .status  (status),
    .cmd     (cmd)
  );

  ahr_datapath u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .status   (status),
    .in_op    (s_tuser),
    .in_data  (s_tdata),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .out_valid(m_tvalid),
    .out_ready(m_tready),
    .out_data (m_tdata),
    .out_kind (m_tuser),
    .out_last (m_tlast)
  );

  a_commit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> status.out_free)
    else $error("commit while output register occupied");

  a_commit_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> m_tvalid)
    else $error("committed result not presented");

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |-> !cmd.commit)
    else $error("command taken while another commits");

  a_last_is_replay: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tlast) |-> (m_tuser == ahr_pkg::KIND_REPLAY))
    else $error("last flag on a non-replay result");

endmodule

// File: bench/audio_history_ring_with_replay_core_tb.sv
// ----------------------------------------------------------------------------
// audio_history_ring_with_replay_core_tb
// Self-checking bench for the audio history ring. Commands are queued by a
// sequencer, driven by a stream driver with random gaps, and predicted at
// the input transfer. Results are checked in order at the output transfer.
// Covers client registration, drain refusals, replay with last marking,
// short-history refusals at wide formats, and several channel/rate/size formats.
// ----------------------------------------------------------------------------
module audio_history_ring_with_replay_core_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int SETTLE_CYCLES = 8;

  typedef struct packed {
    logic [ahr_pkg::OP_W-1:0]   op;
    logic [ahr_pkg::BYTE_W-1:0] sample;
    logic [ahr_pkg::ID_W-1:0]   id;
    logic [ahr_pkg::MS_W-1:0]   ms;
    logic                       ready;
  } item_t;

  typedef struct packed {
    logic [ahr_pkg::KIND_W-1:0]   kind;
    logic                         dest;
    logic [ahr_pkg::BYTE_W-1:0]   value;
    logic [ahr_pkg::STATUS_W-1:0] code;
    logic                         last;
  } reply_t;

  logic                          clk;
  logic                          rst = 1'b1;
  logic                          s_tvalid = 1'b0;
  logic                          s_tready;
  logic [ahr_pkg::S_TDATA_W-1:0] s_tdata = '0;
  logic [ahr_pkg::OP_W-1:0]      s_tuser = '0;
  logic                          m_tvalid;
  logic                          m_tready = 1'b0;
  logic [ahr_pkg::M_TDATA_W-1:0] m_tdata;
  logic [ahr_pkg::KIND_W-1:0]    m_tuser;
  logic                          m_tlast;
  logic                          cfg_we = 1'b0;
  logic [ahr_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [ahr_pkg::CFG_W-1:0]     cfg_data = '0;

  audio_history_ring_with_replay_core DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // shadow of the block state
  logic [ahr_pkg::BYTE_W-1:0]  ring_mem [ahr_pkg::HISTORY_BYTES];
  logic [ahr_pkg::HIST_AW-1:0] wr_pos = '0;
  logic [ahr_pkg::HIST_AW-1:0] replay_pos = '0;
  int unsigned                 fill_cnt = 0;
  bit                          full_flag = 1'b0;
  logic [1:0]                  replay_mode = ahr_pkg::MODE_BUFFERING;
  int unsigned                 replay_left = 0;
  bit                          client_on [ahr_pkg::MAX_CLIENTS];
  logic [ahr_pkg::MS_W-1:0]    client_ms [ahr_pkg::MAX_CLIENTS];
  int unsigned                 n_clients = 0;
  int unsigned                 ch_cfg = 2;
  int unsigned                 rate_cfg = 16;
  int unsigned                 sb_cfg = 2;

  item_t  cmd_q [$];
  reply_t replies_due [$];
  int     errors = 0;
  bit     quiet = 1'b0;
  bit     pressure_go = 1'b0;
  logic   in_xfer = 1'b0;

  // sequencer view of what has been queued so far
  int unsigned gen_fill = 0;
  bit          gen_reg [ahr_pkg::MAX_CLIENTS];
  int unsigned gen_clients = 0;
  int unsigned gen_bpm = 64;

  initial begin
    for (int i = 0; i < ahr_pkg::MAX_CLIENTS; i++) begin
      client_on[i] = 1'b0;
      client_ms[i] = '0;
      gen_reg[i] = 1'b0;
    end
  end

  function automatic reply_t history_op(item_t c);
    reply_t      r;
    int unsigned depth;
    int unsigned avail;
    r = '0;
    r.kind = ahr_pkg::KIND_STATUS;
    case (c.op)
      ahr_pkg::OP_STREAM: begin
        ring_mem[wr_pos] = c.sample;
        wr_pos = wr_pos + 1'b1;
        if (fill_cnt < ahr_pkg::HISTORY_BYTES) fill_cnt++;
        if (fill_cnt >= ahr_pkg::HISTORY_BYTES) full_flag = 1'b1;
        r.kind = ahr_pkg::KIND_PASS;
        r.dest = (replay_mode == ahr_pkg::MODE_ON_DEMAND);
        r.value = c.sample;
      end
      ahr_pkg::OP_REGISTER: begin
        if (c.id >= ahr_pkg::MAX_CLIENTS || n_clients >= ahr_pkg::MAX_CLIENTS)
          r.code = ahr_pkg::ST_BAD_ID;
        else if (client_on[c.id[ahr_pkg::CID_W-1:0]]) r.code = ahr_pkg::ST_DUPLICATE;
        else begin
          client_on[c.id[ahr_pkg::CID_W-1:0]] = 1'b1;
          client_ms[c.id[ahr_pkg::CID_W-1:0]] = c.ms;
          n_clients++;
          r.code = ahr_pkg::ST_OK;
        end
      end
      ahr_pkg::OP_DRAIN: begin
        avail = full_flag ? ahr_pkg::HISTORY_BYTES : fill_cnt;
        depth = c.ms * ch_cfg * rate_cfg * sb_cfg;
        if (c.id >= ahr_pkg::MAX_CLIENTS || !client_on[c.id[ahr_pkg::CID_W-1:0]])
          r.code = ahr_pkg::ST_BAD_ID;
        else if (!c.ready) r.code = ahr_pkg::ST_SINK_BUSY;
        else if (depth > avail) r.code = ahr_pkg::ST_SHORT;
        else begin
          replay_pos = wr_pos - depth[ahr_pkg::HIST_AW-1:0];
          replay_left = depth;
          replay_mode = (depth == 0) ? ahr_pkg::MODE_ON_DEMAND : ahr_pkg::MODE_DRAINING;
          r.code = ahr_pkg::ST_OK;
        end
      end
      default: begin
        if (replay_mode != ahr_pkg::MODE_DRAINING || replay_left == 0)
          r.code = ahr_pkg::ST_NOT_DRAINING;
        else begin
          r.kind = ahr_pkg::KIND_REPLAY;
          r.dest = 1'b1;
          r.value = ring_mem[replay_pos];
          replay_pos = replay_pos + 1'b1;
          replay_left--;
          r.last = (replay_left == 0);
          if (r.last) replay_mode = ahr_pkg::MODE_ON_DEMAND;
        end
      end
    endcase
    return r;
  endfunction

  function automatic void note_error(string msg);
    errors++;
    if (errors <= 10) $display("mismatch at %0t ns: %s", $time, msg);
  endfunction

  // result check first, then predict the command taken at this edge
  always @(posedge clk) begin : out_side
    reply_t got;
    reply_t want;
    item_t  taken;
    if (!rst) begin
      in_xfer <= s_tvalid && s_tready;
      if (m_tvalid && m_tready) begin
        got.kind = m_tuser;
        got.dest = m_tdata[0];
        got.value = m_tdata[8:1];
        got.code = m_tdata[11:9];
        got.last = m_tlast;
        if (replies_due.size() == 0)
          note_error($sformatf("result with nothing pending: kind %0d byte %02h",
                               got.kind, got.value));
        else begin
          want = replies_due.pop_front();
          if (got.kind !== want.kind || got.dest !== want.dest || got.value !== want.value ||
              got.code !== want.code || got.last !== want.last)
            note_error($sformatf({"exp kind %0d dest %0d byte %02h status %0d last %0d, ",
                                  "got kind %0d dest %0d byte %02h status %0d last %0d"},
                                 want.kind, want.dest, want.value, want.code, want.last,
                                 got.kind, got.dest, got.value, got.code, got.last));
        end
      end
      if (s_tvalid && s_tready) begin
        taken.op = s_tuser;
        taken.sample = s_tdata[7:0];
        taken.id = s_tdata[11:8];
        taken.ms = s_tdata[23:12];
        taken.ready = s_tdata[24];
        replies_due.push_back(history_op(taken));
      end
    end
  end

  // command driver
  always @(negedge clk) begin : cmd_driver
    item_t cur;
    int    gap;
    int    r;
    if (rst) begin
      s_tvalid <= 1'b0;
      gap = 0;
    end else if (!s_tvalid || in_xfer) begin
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        gap--;
      end else if (cmd_q.size() > 0) begin
        cur = cmd_q.pop_front();
        s_tvalid <= 1'b1;
        s_tuser <= cur.op;
        s_tdata <= {7'd0, cur.ready, cur.ms, cur.id, cur.sample};
        r = $urandom_range(0, 99);
        if (quiet || r < 60) gap = 0;
        else if (r < 90) gap = $urandom_range(1, 3);
        else if (r < 98) gap = $urandom_range(4, 10);
        else gap = $urandom_range(20, 60);
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // result sink with random stalls and one long hold-off
  always @(negedge clk) begin : result_sink
    int hold;
    int r;
    bit pressure_done;
    if (rst) begin
      m_tready <= 1'b0;
      hold = 0;
      pressure_done = 1'b0;
    end else begin
      if (pressure_go && !pressure_done) begin
        hold = 400;
        pressure_done = 1'b1;
      end
      r = $urandom_range(0, 99);
      if (hold > 0) begin
        m_tready <= 1'b0;
        hold--;
      end else if (quiet || r >= 10) begin
        m_tready <= 1'b1;
      end else begin
        m_tready <= 1'b0;
        hold = (r < 8) ? $urandom_range(0, 3) : $urandom_range(10, 40);
      end
    end
  end

  always @(posedge clk) begin : watchdog
    int cycles;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic void queue_cmd(logic [ahr_pkg::OP_W-1:0] op,
                                    logic [ahr_pkg::BYTE_W-1:0] sample,
                                    logic [ahr_pkg::ID_W-1:0] id,
                                    logic [ahr_pkg::MS_W-1:0] ms, logic ready);
    item_t c;
    c.op = op;
    c.sample = sample;
    c.id = id;
    c.ms = ms;
    c.ready = ready;
    cmd_q.push_back(c);
    if (op == ahr_pkg::OP_STREAM && gen_fill < ahr_pkg::HISTORY_BYTES) gen_fill++;
    if (op == ahr_pkg::OP_REGISTER && id < ahr_pkg::MAX_CLIENTS &&
        gen_clients < ahr_pkg::MAX_CLIENTS && !gen_reg[id[ahr_pkg::CID_W-1:0]]) begin
      gen_reg[id[ahr_pkg::CID_W-1:0]] = 1'b1;
      gen_clients++;
    end
  endfunction

  function automatic void queue_noise(logic [ahr_pkg::OP_W-1:0] op);
    queue_cmd(op, ahr_pkg::BYTE_W'($urandom), ahr_pkg::ID_W'($urandom),
              ahr_pkg::MS_W'($urandom), 1'($urandom));
  endfunction

  // a drain request followed by the ticks that replay it, with live bytes mixed in
  function automatic int drain_episode();
    int unsigned id;
    int unsigned ms;
    int unsigned max_ms;
    int unsigned lim;
    int unsigned depth;
    int          n;
    int          made;
    logic        ready;
    bit          ok;
    made = 1;
    if (gen_clients > 0 && $urandom_range(0, 99) < 85) begin
      id = $urandom_range(0, ahr_pkg::MAX_CLIENTS - 1);
      while (!gen_reg[id]) id = $urandom_range(0, ahr_pkg::MAX_CLIENTS - 1);
    end else begin
      id = $urandom_range(0, 15);
    end
    ready = ($urandom_range(0, 9) != 0);
    if (gen_bpm == 0) begin
      ms = $urandom_range(0, 4095);
    end else begin
      max_ms = gen_fill / gen_bpm;
      lim = (gen_bpm >= 80) ? 1 : 80 / gen_bpm;
      if (max_ms > lim) max_ms = lim;
      ms = $urandom_range(0, max_ms);
      if ($urandom_range(0, 19) == 0) ms = max_ms + 1;
    end
    depth = ms * gen_bpm;
    ok = id < ahr_pkg::MAX_CLIENTS && ready && depth <= gen_fill;
    if (ok) ok = gen_reg[id];
    queue_cmd(ahr_pkg::OP_DRAIN, ahr_pkg::BYTE_W'($urandom), ahr_pkg::ID_W'(id),
              ahr_pkg::MS_W'(ms), ready);
    if (!ok) n = $urandom_range(0, 2);
    else if (depth <= 60) n = depth + $urandom_range(0, 1);
    else n = $urandom_range(1, 40);
    if (ok && $urandom_range(0, 9) == 0) n = $urandom_range(0, n);
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 99) < 15) begin
        queue_noise(ahr_pkg::OP_STREAM);
        made++;
      end
      queue_noise(ahr_pkg::OP_TICK);
      made++;
    end
    return made;
  endfunction

  function automatic void random_mix(int target);
    int made;
    int pick;
    int n;
    made = 0;
    while (made < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        n = $urandom_range(1, 30);
        repeat (n) queue_noise(ahr_pkg::OP_STREAM);
        made += n;
      end else if (pick < 75) begin
        made += drain_episode();
      end else if (pick < 83) begin
        queue_cmd(ahr_pkg::OP_REGISTER, ahr_pkg::BYTE_W'($urandom),
                  ahr_pkg::ID_W'($urandom_range(0, 1) ? $urandom_range(0, 3)
                                                       : $urandom_range(0, 15)),
                  ahr_pkg::MS_W'($urandom), 1'($urandom));
        made++;
      end else if (pick < 90) begin
        queue_noise(ahr_pkg::OP_TICK);
        made++;
      end else begin
        queue_noise(ahr_pkg::OP_W'($urandom));
        made++;
      end
    end
  endfunction

  // wait until the block has nothing in flight, then let it finish up
  task automatic settle();
    while (cmd_q.size() != 0 || s_tvalid || replies_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [ahr_pkg::CFG_IDX_W-1:0] idx,
                           logic [ahr_pkg::CFG_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_format(int unsigned ch, int unsigned rate, int unsigned sb);
    settle();
    write_reg(ahr_pkg::CFG_NUM_CHANNELS, ahr_pkg::CFG_W'(ch));
    write_reg(ahr_pkg::CFG_SAMPLE_RATE, ahr_pkg::CFG_W'(rate));
    write_reg(ahr_pkg::CFG_SAMPLE_BYTES, ahr_pkg::CFG_W'(sb));
    ch_cfg = ch & 4'hF;
    rate_cfg = rate & 6'h3F;
    sb_cfg = sb & 3'h7;
    gen_bpm = ch_cfg * rate_cfg * sb_cfg;
  endtask

  initial begin : sequencer
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: 8 bytes per ms
    set_format(1, 8, 1);
    queue_cmd(ahr_pkg::OP_TICK, 8'h00, 4'd0, 12'd0, 1'b0);
    queue_cmd(ahr_pkg::OP_DRAIN, 8'h00, 4'd0, 12'd1, 1'b1);        // unregistered client
    queue_cmd(ahr_pkg::OP_REGISTER, 8'h00, 4'd15, 12'd4095, 1'b1); // id out of range
    queue_cmd(ahr_pkg::OP_REGISTER, 8'h00, 4'd0, 12'd4095, 1'b0);
    queue_cmd(ahr_pkg::OP_REGISTER, 8'h00, 4'd0, 12'd0, 1'b0);     // duplicate
    queue_cmd(ahr_pkg::OP_DRAIN, 8'h00, 4'd0, 12'd1, 1'b0);        // sink not ready
    queue_cmd(ahr_pkg::OP_DRAIN, 8'h00, 4'd0, 12'd4095, 1'b1);     // history too short
    queue_cmd(ahr_pkg::OP_DRAIN, 8'h00, 4'd0, 12'd0, 1'b1);        // zero depth -> on demand
    queue_cmd(ahr_pkg::OP_STREAM, 8'hFF, 4'd0, 12'd0, 1'b0);
    queue_cmd(ahr_pkg::OP_STREAM, 8'h00, 4'd0, 12'd0, 1'b0);
    repeat (6) queue_cmd(ahr_pkg::OP_STREAM, ahr_pkg::BYTE_W'($urandom), 4'd0, 12'd0, 1'b0);
    queue_cmd(ahr_pkg::OP_DRAIN, 8'h00, 4'd0, 12'd1, 1'b1);        // replay all 8 bytes
    queue_cmd(ahr_pkg::OP_TICK, 8'h00, 4'd0, 12'd0, 1'b0);
    queue_cmd(ahr_pkg::OP_STREAM, 8'h5A, 4'd0, 12'd0, 1'b0);       // live byte mid-replay
    repeat (7) queue_cmd(ahr_pkg::OP_TICK, 8'h00, 4'd0, 12'd0, 1'b0);
    queue_cmd(ahr_pkg::OP_TICK, 8'h00, 4'd0, 12'd0, 1'b0);         // replay already done

    random_mix(100);

    set_format(2, 16, 2);
    random_mix(110);
    pressure_go = 1'b1;

    set_format(3, 10, 1);
    quiet = 1'b1;
    random_mix(60);
    settle();
    quiet = 1'b0;
    random_mix(60);

    // zero channels: every depth is zero
    set_format(0, 63, 7);
    random_mix(50);

    // wide format: requests outrun the history held, live bytes keep flowing
    set_format(8, 32, 4);
    quiet = 1'b1;
    repeat (16) queue_cmd(ahr_pkg::OP_STREAM, ahr_pkg::BYTE_W'($urandom), 4'd0, 12'd0, 1'b0);
    queue_cmd(ahr_pkg::OP_DRAIN, 8'h00, 4'd0, 12'd64, 1'b1);
    repeat (4) begin
      queue_cmd(ahr_pkg::OP_STREAM, ahr_pkg::BYTE_W'($urandom), 4'd0, 12'd0, 1'b0);
      queue_cmd(ahr_pkg::OP_TICK, 8'h00, 4'd0, 12'd0, 1'b0);
    end
    queue_cmd(ahr_pkg::OP_DRAIN, 8'h00, 4'd0, 12'd65, 1'b1);
    queue_cmd(ahr_pkg::OP_DRAIN, 8'h00, 4'd0, 12'd0, 1'b1);
    repeat (3) queue_cmd(ahr_pkg::OP_TICK, 8'h00, 4'd0, 12'd0, 1'b0);
    settle();
    quiet = 1'b0;

    set_format(8, 48, 4);
    random_mix(60);
    set_format(15, 63, 7);
    random_mix(40);
    settle();

    if (errors == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule
